// ----- design/sm3_pkg.sv -----
`timescale 1ns / 1ps
package sm3_pkg;

    localparam int WordW     = 32;
    localparam int FifoDepth = 4;

    localparam logic [31:0] T_LOW   = 32'h79cc4519;
    localparam logic [31:0] T_HIGH  = 32'h7a879d8a;
    localparam logic [31:0] PAD_BIT = 32'h80000000;

    localparam logic [255:0] SM3_IV = {
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    // Word handed from the front end to the block engine.
    typedef struct packed {
        logic [31:0] data;
        logic        block_end;  // Sixteenth word of a block.
        logic        msg_end;    // Final word of the padded message.
    } sm3_word_t;

    typedef enum logic [2:0] {
        FE_MSG,
        FE_PAD,
        FE_ZERO,
        FE_LEN_HI,
        FE_LEN_LO
    } fe_state_t;

    typedef enum logic [1:0] {
        BE_LOAD,
        BE_ROUND,
        BE_EMIT
    } be_state_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

// ----- design/sm3_if.sv -----
`timescale 1ns / 1ps
interface sm3_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] msg_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
    modport source (output valid, msg_word, valid_bytes, last_word, input ready);
    modport sink (input valid, msg_word, valid_bytes, last_word, output ready);
endinterface

interface sm3_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  digest_index;
    logic        digest_last;
    modport source (output valid, digest_word, digest_index, digest_last, input ready);
    modport sink (input valid, digest_word, digest_index, digest_last, output ready);
endinterface

// ----- design/sm3_front.sv -----
`timescale 1ns / 1ps
module sm3_front
    import sm3_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic [31:0] in_word,
    input  logic [2:0] in_bytes,
    input  logic      in_last,
    output logic      wr_valid,
    input  logic      wr_ready,
    output sm3_word_t wr_data
);

    fe_state_t   state_reg, state_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [63:0] len_reg, len_next;

    logic [2:0]  nb;
    logic [63:0] len_add;
    logic [31:0] keep;
    logic [31:0] marker;
    logic        full_last;

    always_comb
    begin
        nb        = (in_bytes > 3'd4) ? 3'd4 : in_bytes;
        full_last = (nb == 3'd4);
        len_add   = in_last ? (len_reg + {58'd0, nb, 3'd0}) : (len_reg + 64'd32);
        unique case (nb)
            3'd0:    begin keep = 32'h00000000; marker = 32'h80000000; end
            3'd1:    begin keep = 32'hff000000; marker = 32'h00800000; end
            3'd2:    begin keep = 32'hffff0000; marker = 32'h00008000; end
            3'd3:    begin keep = 32'hffffff00; marker = 32'h00000080; end
            default: begin keep = 32'hffffffff; marker = 32'h00000000; end
        endcase
    end

    // Next-state logic.
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        len_next      = len_reg;
        unique case (state_reg)
            FE_MSG:
            begin
                if (in_valid && wr_ready)
                begin
                    len_next = len_add;
                    cnt_next = cnt_reg + 4'd1;
                    if (in_last)
                    begin
                        if (full_last)
                            state_next = FE_PAD;
                        else if (cnt_reg == 4'd13)
                            state_next = FE_LEN_HI;
                        else
                            state_next = FE_ZERO;
                    end
                end
            end
            FE_PAD:
            begin
                if (wr_ready)
                begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = (cnt_reg == 4'd13) ? FE_LEN_HI : FE_ZERO;
                end
            end
            FE_ZERO:
            begin
                if (wr_ready)
                begin
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == 4'd13)
                        state_next = FE_LEN_HI;
                end
            end
            FE_LEN_HI:
            begin
                if (wr_ready)
                begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = FE_LEN_LO;
                end
            end
            FE_LEN_LO:
            begin
                if (wr_ready)
                begin
                    cnt_next   = 4'd0;
                    len_next   = 64'd0;
                    state_next = FE_MSG;
                end
            end
            default: state_next = FE_MSG;
        endcase
    end

    // Output logic.
    always_comb
    begin
        in_ready          = 1'b0;
        wr_valid          = 1'b0;
        wr_data.data      = 32'd0;
        wr_data.block_end = (cnt_reg == 4'd15);
        wr_data.msg_end   = 1'b0;
        unique case (state_reg)
            FE_MSG:
            begin
                in_ready     = wr_ready;
                wr_valid     = in_valid;
                wr_data.data = in_last ? ((in_word & keep) | marker) : in_word;
            end
            FE_PAD:
            begin
                wr_valid     = 1'b1;
                wr_data.data = PAD_BIT;
            end
            FE_ZERO:   wr_valid = 1'b1;
            FE_LEN_HI:
            begin
                wr_valid     = 1'b1;
                wr_data.data = len_reg[63:32];
            end
            FE_LEN_LO:
            begin
                wr_valid        = 1'b1;
                wr_data.data    = len_reg[31:0];
                wr_data.msg_end = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FE_MSG;
            cnt_reg   <= 4'd0;
            len_reg   <= 64'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            len_reg   <= len_next;
        end
    end

endmodule

// ----- design/sm3_fifo.sv -----
`timescale 1ns / 1ps
module sm3_fifo
    import sm3_pkg::*;
#(
    parameter int Depth = FifoDepth
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_valid,
    output logic      wr_ready,
    input  sm3_word_t wr_data,
    output logic      rd_valid,
    input  logic      rd_ready,
    output sm3_word_t rd_data
);

    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

    sm3_word_t     mem_reg [Depth];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          push, pop;

    assign wr_ready = (cnt_reg != Depth[AW:0]);
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = mem_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == AW'(Depth - 1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == AW'(Depth - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + {{AW{1'b0}}, push} - {{AW{1'b0}}, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= wr_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= Depth[AW:0])
        else $error("fifo count beyond depth");

endmodule

// ----- design/sm3_core.sv -----
`timescale 1ns / 1ps
module sm3_core
    import sm3_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rd_valid,
    output logic        rd_ready,
    input  sm3_word_t   rd_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_word,
    output logic [2:0]  out_index,
    output logic        out_last
);

    be_state_t   state_reg, state_next;
    logic [31:0] win_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] r_reg [8];
    logic [5:0]  rnd_reg;
    logic        fin_reg;
    logic [2:0]  idx_reg;

    logic [31:0] w_j, w_j4, w_new, ff, gg, tt1, tt2, ss1, ss2, a12, tj;
    logic        take, round_done;

    assign take       = (state_reg == BE_LOAD) && rd_valid;
    assign round_done = (state_reg == BE_ROUND) && (rnd_reg == 6'd63);

    // The window holds W[j..j+15]; each round shifts in W[j+16].
    always_comb
    begin
        w_j   = win_reg[0];
        w_j4  = win_reg[4];
        w_new = p1(win_reg[0] ^ win_reg[7] ^ rotl(win_reg[13], 5'd15))
                ^ rotl(win_reg[3], 5'd7) ^ win_reg[10];
        tj    = rotl((rnd_reg < 6'd16) ? T_LOW : T_HIGH, rnd_reg[4:0]);
        a12   = rotl(r_reg[0], 5'd12);
        ss1   = rotl(a12 + r_reg[4] + tj, 5'd7);
        ss2   = ss1 ^ a12;
        ff    = (rnd_reg < 6'd16) ? (r_reg[0] ^ r_reg[1] ^ r_reg[2])
              : ((r_reg[0] & r_reg[1]) | (r_reg[0] & r_reg[2]) | (r_reg[1] & r_reg[2]));
        gg    = (rnd_reg < 6'd16) ? (r_reg[4] ^ r_reg[5] ^ r_reg[6])
              : ((r_reg[4] & r_reg[5]) | (~r_reg[4] & r_reg[6]));
        tt1   = ff + r_reg[3] + ss2 + (w_j ^ w_j4);
        tt2   = gg + r_reg[7] + ss1 + w_j;
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BE_LOAD:  if (take && rd_data.block_end) state_next = BE_ROUND;
            BE_ROUND: if (round_done) state_next = fin_reg ? BE_EMIT : BE_LOAD;
            BE_EMIT:  if (out_ready && idx_reg == 3'd7) state_next = BE_LOAD;
            default:  state_next = BE_LOAD;
        endcase
    end

    // Output logic.
    always_comb
    begin
        rd_ready  = (state_reg == BE_LOAD);
        out_valid = (state_reg == BE_EMIT);
        out_word  = v_reg[idx_reg];
        out_index = idx_reg;
        out_last  = (idx_reg == 3'd7);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BE_LOAD;
            rnd_reg   <= 6'd0;
            fin_reg   <= 1'b0;
            idx_reg   <= 3'd0;
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= SM3_IV[255 - 32*i -: 32];
                r_reg[i] <= 32'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (take && rd_data.block_end)
            begin
                fin_reg <= rd_data.msg_end;
                rnd_reg <= 6'd0;
                for (int i = 0; i < 8; i++)
                    r_reg[i] <= v_reg[i];
            end
            if (state_reg == BE_ROUND)
            begin
                rnd_reg  <= rnd_reg + 6'd1;
                r_reg[0] <= tt1;
                r_reg[1] <= r_reg[0];
                r_reg[2] <= rotl(r_reg[1], 5'd9);
                r_reg[3] <= r_reg[2];
                r_reg[4] <= p0(tt2);
                r_reg[5] <= r_reg[4];
                r_reg[6] <= rotl(r_reg[5], 5'd19);
                r_reg[7] <= r_reg[6];
            end
            if (round_done)
            begin
                v_reg[0] <= v_reg[0] ^ tt1;
                v_reg[1] <= v_reg[1] ^ r_reg[0];
                v_reg[2] <= v_reg[2] ^ rotl(r_reg[1], 5'd9);
                v_reg[3] <= v_reg[3] ^ r_reg[2];
                v_reg[4] <= v_reg[4] ^ p0(tt2);
                v_reg[5] <= v_reg[5] ^ r_reg[4];
                v_reg[6] <= v_reg[6] ^ rotl(r_reg[5], 5'd19);
                v_reg[7] <= v_reg[7] ^ r_reg[6];
            end
            if (state_reg == BE_EMIT && out_ready)
            begin
                idx_reg <= idx_reg + 3'd1;
                if (idx_reg == 3'd7)
                    for (int i = 0; i < 8; i++)
                        v_reg[i] <= SM3_IV[255 - 32*i -: 32];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int i = 0; i < 15; i++)
                win_reg[i] <= win_reg[i+1];
            win_reg[15] <= rd_data.data;
        end
        else if (state_reg == BE_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                win_reg[i] <= win_reg[i+1];
            win_reg[15] <= w_new;
        end
    end

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != BE_LOAD) |-> !rd_ready)
        else $error("word taken while engine busy");
    a_rounds_end: assert property (@(posedge clk) disable iff (!rst_n)
        round_done |=> (state_reg == BE_LOAD || state_reg == BE_EMIT))
        else $error("round loop did not end");
    a_emit_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (idx_reg == 3'd0))
        else $error("digest does not start at word zero");

endmodule

// ----- design/sm3_hash.sv -----
`timescale 1ns / 1ps
// Channel  Dir  Payload                                  Handshake
// msg_in   in   msg_word[32] valid_bytes[3] last_word    valid/ready
// dig_out  out  digest_word[32] digest_index[3] last     valid/ready
//
// The front end takes one request per cycle unless the queue is full or it is
// padding; it applies padding and queues words. The compression engine loads
// a block's words, then runs its rounds, one round per cycle.
// Padding adds up to 18 words; the digest then leaves as eight requests.
// rst_n clears control state asynchronously and reloads the IV.
// Either side may stall; the queue lets the front end run ahead of the engine.
module sm3_hash
    import sm3_pkg::*;
#(
    parameter int QueueDepth = FifoDepth
)
(
    input logic clk,
    input logic rst_n,
    sm3_in_if.sink    msg_in,
    sm3_out_if.source dig_out
);

    logic      q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
    sm3_word_t q_wr_data, q_rd_data;

    sm3_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (msg_in.valid),
        .in_ready (msg_in.ready),
        .in_word  (msg_in.msg_word),
        .in_bytes (msg_in.valid_bytes),
        .in_last  (msg_in.last_word),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data)
    );

    sm3_fifo #(.Depth(QueueDepth)) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_data  (q_wr_data),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_data  (q_rd_data)
    );

    sm3_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_valid  (q_rd_valid),
        .rd_ready  (q_rd_ready),
        .rd_data   (q_rd_data),
        .out_valid (dig_out.valid),
        .out_ready (dig_out.ready),
        .out_word  (dig_out.digest_word),
        .out_index (dig_out.digest_index),
        .out_last  (dig_out.digest_last)
    );

endmodule

// ----- tb/sm3_hash_test.sv -----
`timescale 1ns / 1ps
module sm3_hash_test;
    import sm3_pkg::*;

    // Directed rows: word, byte count, last flag, and an optional typed digest.
    typedef struct {
        logic [31:0]  word;
        logic [2:0]   nbytes;
        logic         last;
        bit           has_digest;
        logic [255:0] digest;
    } msg_row_t;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_item_t;

    logic clk;
    logic rst_n;

    sm3_in_if  msg_in();
    sm3_out_if dig_out();

    sm3_hash dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .msg_in  (msg_in.sink),
        .dig_out (dig_out.source)
    );

    // Clock: 10 ns period.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Predictor state: the running chaining value, the partly filled block and
    // the bit length of the message so far.
    logic [31:0]  chain[8];
    logic [31:0]  block_buf[16];
    int unsigned  block_fill;
    logic [63:0]  bit_len;
    digest_item_t digest_queue[$];

    int errors;
    int sent_items;
    int got_results;
    int messages_done;
    int idle_cycles = 0;

    // Idle percentages for the two sides; changed between phases.
    int src_idle_pct;
    int snk_stall_pct;

    function automatic logic [31:0] rot(input logic [31:0] x, input int n);
        if (n % 32 == 0)
        begin
            return x;
        end
        return (x << (n % 32)) | (x >> (32 - n % 32));
    endfunction

    function automatic logic [31:0] perm_a(input logic [31:0] x);
        return x ^ rot(x, 9) ^ rot(x, 17);
    endfunction

    function automatic logic [31:0] perm_b(input logic [31:0] x);
        return x ^ rot(x, 15) ^ rot(x, 23);
    endfunction

    task automatic restart_message();
        for (int i = 0; i < 8; i++)
        begin
            chain[i] = SM3_IV[255 - 32 * i -: 32];
        end
        block_fill = 0;
        bit_len    = '0;
    endtask

    // One full compression of the buffered block into the chaining value.
    task automatic compress_block();
        logic [31:0] w[68];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] tc, a12, ss1, ss2, ff, gg, tt1, tt2;
        for (int j = 0; j < 16; j++)
        begin
            w[j] = block_buf[j];
        end
        for (int j = 16; j < 68; j++)
        begin
            w[j] = perm_b(w[j - 16] ^ w[j - 9] ^ rot(w[j - 3], 15))
                   ^ rot(w[j - 13], 7) ^ w[j - 6];
        end
        {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                    chain[4], chain[5], chain[6], chain[7]};
        for (int j = 0; j < 64; j++)
        begin
            tc  = (j < 16) ? T_LOW : T_HIGH;
            a12 = rot(a, 12);
            ss1 = rot(a12 + e + rot(tc, j), 7);
            ss2 = ss1 ^ a12;
            ff  = (j < 16) ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
            gg  = (j < 16) ? (e ^ f ^ g) : ((e & f) | (~e & g));
            tt1 = ff + d + ss2 + (w[j] ^ w[j + 4]);
            tt2 = gg + h + ss1 + w[j];
            d = c;
            c = rot(b, 9);
            b = a;
            a = tt1;
            h = g;
            g = rot(f, 19);
            f = e;
            e = perm_a(tt2);
        end
        chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
        chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
    endtask

    task automatic append_word(input logic [31:0] word);
        block_buf[block_fill] = word;
        block_fill++;
        if (block_fill == 16)
        begin
            compress_block();
            block_fill = 0;
        end
    endtask

    // Advances the predictor by one accepted request; on the last word it pads,
    // finishes the hash and queues the eight digest words.
    task automatic hash_request(input logic [31:0] word, input logic [2:0] nbytes_in,
                                input logic last);
        int unsigned  nb;
        logic [31:0]  keep;
        if (!last)
        begin
            // A word that is not last always carries four bytes.
            bit_len += 64'd32;
            append_word(word);
            return;
        end
        nb = (nbytes_in > 3'd4) ? 4 : nbytes_in;
        bit_len += 64'(8 * nb);
        if (nb == 4)
        begin
            append_word(word);
            append_word(PAD_BIT);
        end
        else
        begin
            keep = (nb == 0) ? 32'h0 : (32'hffffffff << (8 * (4 - nb)));
            append_word((word & keep) | (32'h80 << (8 * (3 - nb))));
        end
        if (block_fill > 14)
        begin
            append_word(32'h0);
        end
        while (block_fill < 14)
        begin
            append_word(32'h0);
        end
        append_word(bit_len[63:32]);
        append_word(bit_len[31:0]);
        for (int k = 0; k < 8; k++)
        begin
            digest_queue.push_back('{word: chain[k], index: 3'(k), last: (k == 7)});
        end
        restart_message();
    endtask

    // Source side: holds the request until it is accepted, idling at random
    // beforehand according to the current phase. Valid stays high into the next
    // request when there is no idle cycle in between.
    task automatic send_request(input logic [31:0] word, input logic [2:0] nbytes,
                                input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            msg_in.valid <= 1'b0;
            @(posedge clk);
        end
        msg_in.valid       <= 1'b1;
        msg_in.msg_word    <= word;
        msg_in.valid_bytes <= nbytes;
        msg_in.last_word   <= last;
        do
        begin
            @(posedge clk);
        end
        while (!msg_in.ready);
        hash_request(word, nbytes, last);
        sent_items++;
    endtask

    // Sink side stalls at random; ready changes only at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            dig_out.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Result checker: each accepted digest word against the oldest expectation.
    always @(posedge clk)
    begin
        digest_item_t want;
        if (rst_n && dig_out.valid && dig_out.ready)
        begin
            got_results++;
            if (digest_queue.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected digest word %h index %0d last %0b", $time,
                         dig_out.digest_word, dig_out.digest_index, dig_out.digest_last);
            end
            else
            begin
                want = digest_queue.pop_front();
                if (dig_out.digest_word !== want.word)
                begin
                    errors++;
                    $display("%0t: digest_word expected %h actual %h", $time,
                             want.word, dig_out.digest_word);
                end
                if (dig_out.digest_index !== want.index)
                begin
                    errors++;
                    $display("%0t: digest_index expected %0d actual %0d", $time,
                             want.index, dig_out.digest_index);
                end
                if (dig_out.digest_last !== want.last)
                begin
                    errors++;
                    $display("%0t: digest_last expected %0b actual %0b", $time,
                             want.last, dig_out.digest_last);
                end
                if (want.last)
                begin
                    messages_done++;
                end
            end
        end
    end

    // Watchdog: counts cycles with no accepted request on either channel. The
    // worst legitimate gap is a padded two-block finish plus stalled output.
    always @(posedge clk)
    begin
        if ((msg_in.valid && msg_in.ready) || (dig_out.valid && dig_out.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > 20000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Sends a random message; most are well formed, some end on odd counts.
    task automatic send_random_message(input int max_words);
        int n;
        n = $urandom_range(max_words);
        for (int i = 0; i < n; i++)
        begin
            // Non-last words may carry any byte count; it is ignored.
            send_request($urandom, 3'($urandom_range(7)), 1'b0);
        end
        send_request($urandom, 3'($urandom_range(7)), 1'b1);
    endtask

    // Drops valid and waits until every predicted digest word has come back.
    task automatic wait_drained();
        msg_in.valid <= 1'b0;
        while (digest_queue.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Directed table. The first two digests are the standard SM3 test vectors
    // for "abc" and the empty message; the rest are predicted.
    msg_row_t rows[$];

    task automatic add_row(input logic [31:0] word, input logic [2:0] nbytes,
                           input logic last, input bit has_digest = 0,
                           input logic [255:0] digest = '0);
        rows.push_back('{word, nbytes, last, has_digest, digest});
    endtask

    initial
    begin
        logic [255:0] seen;
        errors        = 0;
        sent_items    = 0;
        got_results   = 0;
        messages_done = 0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        rst_n              = 1'b0;
        msg_in.valid       = 1'b0;
        msg_in.msg_word    = '0;
        msg_in.valid_bytes = '0;
        msg_in.last_word   = 1'b0;
        dig_out.ready      = 1'b0;
        restart_message();
        repeat (11)
        begin
            @(posedge clk);
        end
        rst_n <= 1'b1;
        @(posedge clk);

        // "abc" as three bytes on a last word; bytes beyond the count are junk.
        add_row(32'h616263ff, 3'd3, 1'b1, 1'b1,
                256'h66c7f0f462eeedd9d1f2d46bdc10e4e24167c4875cf2f7a2297da02b8f4ba8e0);
        // Empty message.
        add_row(32'hdeadbeef, 3'd0, 1'b1, 1'b1,
                256'h1ab21d8355cfa17f8e61194831e81a8f22bec8c728fefb747ed035eb5082aa2b);
        // Extremes of the word, an oversized count, a partial count ignored on a
        // non-last word, and a fourteen-word message that forces an extra block.
        add_row(32'hffffffff, 3'd7, 1'b1);
        add_row(32'h00000000, 3'd1, 1'b0);
        add_row(32'hffffffff, 3'd2, 1'b1);
        for (int i = 0; i < 13; i++)
        begin
            add_row(32'h5a5aa5a5 ^ i, 3'd4, 1'b0);
        end
        add_row(32'h12345678, 3'd4, 1'b1);
        add_row(32'h80000001, 3'd5, 1'b1);

        foreach (rows[r])
        begin
            send_request(rows[r].word, rows[r].nbytes, rows[r].last);
            if (rows[r].has_digest)
            begin
                for (int k = 0; k < 8; k++)
                begin
                    seen[255 - 32 * k -: 32] = digest_queue[digest_queue.size() - 8 + k].word;
                end
                if (seen !== rows[r].digest)
                begin
                    errors++;
                    $display("%0t: predicted digest expected %h actual %h", $time,
                             rows[r].digest, seen);
                end
            end
        end

        // Random phases: no idling, sender idle, receiver stalling, both.
        for (int phase = 0; phase < 4; phase++)
        begin
            src_idle_pct  = (phase == 1) ? 84 : (phase == 3) ? 28 : 0;
            snk_stall_pct = (phase == 2) ? 84 : (phase == 3) ? 28 : 0;
            for (int m = 0; m < 9; m++)
            begin
                // Mostly short messages, with an occasional multi-block one.
                send_random_message(($urandom_range(9) == 0) ? 40 : 5);
                if (m == 3)
                begin
                    // Hold off until every digest word is back.
                    wait_drained();
                end
            end
        end

        wait_drained();
        repeat (200)
        begin
            @(posedge clk);
        end
        $display("Sent %0d message words in %0d messages; %0d digest words checked.",
                 sent_items, messages_done, got_results);
        $display("Covered all byte counts, padding block boundaries and four idle phases.");
        if (errors == 0 && digest_queue.size() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
design/sm3_pkg.sv
design/sm3_if.sv
design/sm3_front.sv
design/sm3_fifo.sv
design/sm3_core.sv
design/sm3_hash.sv
tb/sm3_hash_test.sv
